@@ design/dbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dbs_pkg;

  localparam int unsigned NUM_PIXELS = 307200;
  localparam int unsigned ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

  // Run length of deeper readings that replaces the background.
  localparam logic [2:0] RUN_TO_REPLACE = 3'd5;
  // Consecutive raw hits before a pixel counts as foreground.
  localparam logic [6:0] STABLE_NEEDED = 7'd5;
  localparam logic [6:0] STABLE_MAX = 7'd100;

  localparam logic [15:0] BG_RESET_MM = 16'd900;
  localparam logic [15:0] MIN_FG_DEPTH_MM = 16'd10;
  localparam logic [15:0] THRESHOLD_RESET_MM = 16'd20;

  // Result buffer depth behind the update stage.
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [15:0] depth_mm;
    logic        exclude;
    logic [18:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic        foreground;
    logic        no_signal;
    logic [15:0] background_mm;
  } out_item_t;

  typedef struct packed {
    logic [15:0] background;
    logic [15:0] shallowest;
    logic [2:0]  run;
    logic [6:0]  stable;
  } pixel_state_t;

  localparam int unsigned STATE_W = $bits(pixel_state_t);

  localparam pixel_state_t STATE_RESET = '{
    background: BG_RESET_MM,
    shallowest: 16'd0,
    run:        3'd0,
    stable:     7'd0
  };

  typedef struct packed {
    logic                 push;
    logic                 pop;
  } fifo_ctrl_t;

endpackage
`default_nettype wire

@@ design/depth_background_subtract_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel depth background subtraction on a streaming depth image.
// Input channel (in_valid / in_stall / in_item): one pixel per transaction,
// depth in mm, exclude bit and raster index. Output channel (out_valid /
// out_stall / out_item): one result per pixel, in input order, with the
// stable foreground bit, the no-signal bit and the updated background.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes threshold_mm;
// cfg_ready is always high. Write it only while the block is idle.
// An accepted pixel is registered into the update stage and then into the result
// buffer, from which it can be taken.
// Throughput: one pixel per cycle while in_stall is low, set by the per-pixel
// state memory, which does one read and one write each cycle; back-to-back hits
// on the same pixel are forwarded from the last write.
// Reset: the state memory is swept to its reset values one entry per cycle,
// all NUM_PIXELS (307200) entries, with in_stall high; threshold resets to 20 mm.
// When the receiver stalls, up to three results are buffered, after which
// in_stall rises until a buffered result is taken.
module depth_background_subtract_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dbs_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output dbs_pkg::out_item_t  out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [15:0]         cfg_data
);
  import dbs_pkg::*;

  logic [15:0]           threshold_mm;

  logic                  clearing;
  logic [ADDR_W-1:0]     clr_addr;

  logic                  in_acc;
  logic                  in_range;
  logic [ADDR_W-1:0]     in_addr;

  logic                  s1_valid;
  logic                  s1_in_range;
  in_item_t              s1_item;
  logic [ADDR_W-1:0]     s1_addr;

  logic                  fwd_valid;
  logic [ADDR_W-1:0]     fwd_addr;
  pixel_state_t          fwd_data;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  pixel_state_t          wr_data;
  logic [STATE_W-1:0]    rd_data;

  pixel_state_t          cur;
  pixel_state_t          upd;
  out_item_t             result;
  fifo_ctrl_t            fifo_ctrl;
  logic [OUT_CNT_W-1:0]  fifo_count;
  logic [OUT_CNT_W:0]    occupancy;

  // Update-stage signals
  logic                  nosig;
  logic                  deeper;
  logic [3:0]            run_sum;
  logic [15:0]           shallow_n;
  logic [3:0]            run_n;
  logic [15:0]           bg_n;
  logic                  raw;
  logic [6:0]            stab_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_mm <= THRESHOLD_RESET_MM;
    end else if (cfg_valid && cfg_ready) begin
      threshold_mm <= cfg_data;
    end
  end

  // Reset sweep of the state memory
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(NUM_PIXELS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Admit a pixel only if its result is sure to find room in the buffer
  assign occupancy = (OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(s1_valid);
  assign in_stall  = clearing || (occupancy >= (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = 32'(in_item.pixel_index) < 32'(NUM_PIXELS);
  assign in_addr   = ADDR_W'(32'(in_item.pixel_index));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item     <= in_item;
      s1_in_range <= in_range;
    end
  end

  assign s1_addr = ADDR_W'(32'(s1_item.pixel_index));

  dbs_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_PIXELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc && in_range),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // Take the previous write when it hit the same pixel
  assign cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : pixel_state_t'(rd_data);

  always_comb begin
    nosig     = (s1_item.depth_mm == 16'd0) || s1_item.exclude;
    deeper    = s1_item.depth_mm > cur.background;
    run_sum   = {1'b0, cur.run} + 4'd1;
    shallow_n = cur.shallowest;
    run_n     = {1'b0, cur.run};
    bg_n      = cur.background;
    if (!nosig) begin
      if (deeper) begin
        if (cur.run == 3'd0 || cur.shallowest > s1_item.depth_mm) begin
          shallow_n = s1_item.depth_mm;
        end
        run_n = run_sum;
      end else begin
        run_n = 4'd0;
      end
      if (run_n >= {1'b0, RUN_TO_REPLACE}) begin
        bg_n  = shallow_n;
        run_n = 4'd0;
      end
    end
    raw = !nosig && (s1_item.depth_mm >= MIN_FG_DEPTH_MM) &&
          ((17'(s1_item.depth_mm) + 17'(threshold_mm)) <= 17'(bg_n));
    if (!raw) begin
      stab_n = 7'd0;
    end else if (cur.stable < STABLE_MAX) begin
      stab_n = cur.stable + 7'd1;
    end else begin
      stab_n = cur.stable;
    end
    upd.background = bg_n;
    upd.shallowest = shallow_n;
    upd.run        = run_n[2:0];
    upd.stable     = stab_n;
    result.no_signal     = nosig;
    result.foreground    = s1_in_range && raw && (stab_n >= STABLE_NEEDED);
    result.background_mm = s1_in_range ? bg_n : 16'd0;
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = STATE_RESET;
    end else begin
      wr_en   = s1_valid && s1_in_range;
      wr_addr = s1_addr;
      wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (!clearing && s1_valid && s1_in_range) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clearing && s1_valid && s1_in_range) begin
      fwd_addr <= s1_addr;
      fwd_data <= upd;
    end
  end

  assign fifo_ctrl.push = s1_valid;
  assign fifo_ctrl.pop  = out_valid && !out_stall;
  assign out_valid      = fifo_count != '0;

  dbs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fifo_ctrl),
    .push_item (result),
    .head_item (out_item),
    .count     (fifo_count)
  );

  a_no_accept_in_sweep : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !out_valid)
    else $error("pixel in flight during memory sweep");

  a_wr_in_range : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> 32'(wr_addr) < 32'(NUM_PIXELS))
    else $error("state write outside memory");

  a_occupancy : assert property (@(posedge clk) disable iff (rst)
    occupancy <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("more results in flight than buffer slots");

  a_accept_reaches_update : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> s1_valid && s1_item == $past(in_item))
    else $error("accepted pixel lost before update");

endmodule
`default_nettype wire

@@ design/dbs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                         clk,
  input  wire                                         wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                            wr_data,
  input  wire                                         rd_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/dbs_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dbs_out_fifo (
  input  wire                           clk,
  input  wire                           rst,
  input  dbs_pkg::fifo_ctrl_t           ctrl,
  input  dbs_pkg::out_item_t            push_item,
  output dbs_pkg::out_item_t            head_item,
  output logic [dbs_pkg::OUT_CNT_W-1:0] count
);
  import dbs_pkg::*;

  out_item_t              entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;

  function automatic logic [OUT_PTR_W-1:0] ptr_inc(input logic [OUT_PTR_W-1:0] p);
    ptr_inc = (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + OUT_PTR_W'(1);
  endfunction

  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (ctrl.pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({ctrl.push, ctrl.pop})
        2'b10:   count <= count + OUT_CNT_W'(1);
        2'b01:   count <= count - OUT_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    ctrl.push && !ctrl.pop |-> count < OUT_CNT_W'(OUT_DEPTH))
    else $error("result buffer overflow");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> count != '0)
    else $error("result buffer underflow");

endmodule
`default_nettype wire

@@ tb/sv/depth_background_subtract_checker.sv @@
`timescale 1ns / 1ps
module depth_background_subtract_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dbs_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dbs_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  outstanding,
  output int                  mismatches
);

  localparam int unsigned PIXEL_COUNT = 307200;
  localparam logic [15:0] BG_INIT_MM = 16'd900;
  localparam logic [15:0] MIN_DEPTH_MM = 16'd10;
  localparam logic [15:0] THRESHOLD_INIT_MM = 16'd20;
  localparam logic [3:0]  RUN_LEN = 4'd5;
  localparam logic [6:0]  HITS_NEEDED = 7'd5;
  localparam logic [6:0]  HITS_CAP = 7'd100;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0] bg;
    logic [15:0] shallow;
    logic [2:0]  run;
    logic [6:0]  hits;
  } px_track_t;

  localparam px_track_t TRACK_INIT = {BG_INIT_MM, 16'd0, 3'd0, 7'd0};

  // Only touched pixels are stored; a missing entry is still at its reset values.
  px_track_t          px_track [int unsigned];
  logic [15:0]        threshold;
  dbs_pkg::out_item_t pixel_verdicts [$];
  int                 errs = 0;

  function automatic dbs_pkg::out_item_t subtract_background(input dbs_pkg::in_item_t px);
    px_track_t          s;
    dbs_pkg::out_item_t r;
    logic               dark;
    logic               raw;
    logic [3:0]         run;
    logic [16:0]        reach;
    dark = (px.depth_mm == 16'd0) || px.exclude;
    r.foreground = 1'b0;
    r.no_signal = dark;
    r.background_mm = 16'd0;
    if (px.pixel_index >= PIXEL_COUNT) return r;

    s = px_track.exists(px.pixel_index) ? px_track[px.pixel_index] : TRACK_INIT;
    if (!dark) begin
      run = {1'b0, s.run};
      if (px.depth_mm > s.bg) begin
        if (run == 4'd0 || s.shallow > px.depth_mm) s.shallow = px.depth_mm;
        run = run + 4'd1;
      end else begin
        run = 4'd0;
      end
      if (run >= RUN_LEN) begin
        s.bg = s.shallow;
        run = 4'd0;
      end
      s.run = run[2:0];
    end

    // Compare in 17 bits so a large threshold cannot wrap.
    reach = {1'b0, px.depth_mm} + {1'b0, threshold};
    raw = !dark && px.depth_mm >= MIN_DEPTH_MM && reach <= {1'b0, s.bg};
    if (!raw) s.hits = 7'd0;
    else if (s.hits < HITS_CAP) s.hits = s.hits + 7'd1;
    px_track[px.pixel_index] = s;

    r.foreground = raw && s.hits >= HITS_NEEDED;
    r.background_mm = s.bg;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    dbs_pkg::out_item_t want;
    if (rst) begin
      px_track.delete();
      pixel_verdicts.delete();
      threshold = THRESHOLD_INIT_MM;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_valid && !in_stall) pixel_verdicts.push_back(subtract_background(in_item));
      if (out_valid && !out_stall) begin
        if (pixel_verdicts.size() == 0) begin
          errs++;
          if (errs <= REPORT_LIMIT)
            $display("%0t: unexpected transaction fg=%0b no_signal=%0b bg=%0d", $realtime,
                     out_item.foreground, out_item.no_signal, out_item.background_mm);
        end else begin
          want = pixel_verdicts.pop_front();
          if (want.foreground !== out_item.foreground || want.no_signal !== out_item.no_signal ||
              want.background_mm !== out_item.background_mm) begin
            errs++;
            if (errs <= REPORT_LIMIT)
              $display("%0t: mismatch fg %0b/%0b no_signal %0b/%0b bg %0d/%0d (expected/actual)",
                       $realtime, want.foreground, out_item.foreground, want.no_signal,
                       out_item.no_signal, want.background_mm, out_item.background_mm);
          end
        end
      end
    end
    outstanding <= pixel_verdicts.size();
    mismatches <= errs;
  end

endmodule

@@ tb/sv/depth_background_subtract_top_tb.sv @@
`timescale 1ns / 1ps
module depth_background_subtract_top_tb;

  // Covers the clearing sweep of all 307200 entries plus a wide margin for stalls and gaps.
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 8;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  dbs_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  dbs_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  int   outstanding;
  int   mismatches;
  int   cycle_count = 0;
  int   pixels_sent = 0;
  logic quiet = 1'b0;

  depth_background_subtract_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  depth_background_subtract_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver pacing: free stretches with stall bursts in between.
  initial begin : sink_pacing
    int span;
    out_stall <= 1'b0;
    forever begin
      span = $urandom_range(1, 40);
      repeat (span) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic [15:0] depth, input logic excl, input logic [18:0] idx);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= {depth, excl, idx};
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Drain all results, then write the threshold while the block is idle.
  task automatic set_threshold(input logic [15:0] mm);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mm;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    int          stop;
    int          k;
    int          n;
    logic [18:0] idx;
    logic [15:0] base;
    stop = pixels_sent + count;
    while (pixels_sent < stop) begin
      case ($urandom_range(0, 7))
        0: idx = 19'd0;
        1: idx = 19'd1;
        2: idx = 19'd42;
        3: idx = 19'd65536;
        4: idx = 19'd131071;
        5: idx = 19'd200000;
        6: idx = 19'd262149;
        default: idx = 19'd307199;
      endcase
      case ($urandom_range(0, 9))
        0, 1: begin
          send_pixel(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     19'($urandom_range(0, 524287)));
        end
        2, 3, 4: begin
          // deeper run, long enough to replace the background most of the time
          base = 16'($urandom_range(901, 65000));
          n = $urandom_range(3, 7);
          for (k = 0; k < n; k++)
            send_pixel(16'(base + $urandom_range(0, 500)), $urandom_range(0, 15) == 0, idx);
        end
        5, 6, 7, 8: begin
          // hold an object in front of the background to build up stability
          base = 16'($urandom_range(10, 700));
          n = $urandom_range(2, 12);
          for (k = 0; k < n; k++)
            send_pixel(16'(base + $urandom_range(0, 40)), $urandom_range(0, 19) == 0, idx);
        end
        default: begin
          send_pixel(16'($urandom_range(0, 2000)), 1'b0, idx);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int k;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 16'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no signal by zero depth and by mask, extreme depth and index
    send_pixel(16'd0, 1'b0, 19'd0);
    send_pixel(16'd500, 1'b1, 19'd0);
    send_pixel(16'd65535, 1'b0, 19'd307199);
    send_pixel(16'd5, 1'b0, 19'd1);
    // exactly at and just past the threshold edge
    send_pixel(16'd880, 1'b0, 19'd2);
    send_pixel(16'd881, 1'b0, 19'd2);
    // index out of range
    send_pixel(16'd100, 1'b0, 19'd307200);
    send_pixel(16'd0, 1'b1, 19'd524287);
    // five deeper readings replace the background with the shallowest one
    send_pixel(16'd1000, 1'b0, 19'd3);
    send_pixel(16'd1200, 1'b0, 19'd3);
    send_pixel(16'd1100, 1'b0, 19'd3);
    send_pixel(16'd1300, 1'b0, 19'd3);
    send_pixel(16'd1050, 1'b0, 19'd3);
    // stability reaches the foreground level, then a dropout clears it
    for (k = 0; k < 6; k++) send_pixel(16'd100, 1'b0, 19'd4);
    send_pixel(16'd0, 1'b0, 19'd4);
    send_pixel(16'd100, 1'b0, 19'd4);
    send_pixel(16'd10, 1'b0, 19'd262144);
    // a reading not deeper breaks the run
    send_pixel(16'd1000, 1'b0, 19'd5);
    send_pixel(16'd900, 1'b0, 19'd5);

    set_threshold(16'd0);
    // hold long enough to saturate the stability count
    for (k = 0; k < 130; k++) send_pixel(16'd50, 1'b0, 19'd77);
    run_phase(110);

    set_threshold(16'd65535);
    run_phase(100);

    // threshold above the reset background
    set_threshold(16'd1000);
    run_phase(100);

    set_threshold(16'($urandom_range(1, 65534)));
    run_phase(100);

    set_threshold(16'd1);
    run_phase(100);

    set_threshold(16'd20);
    quiet = 1'b1;
    run_phase(100);

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
